// ===== hw/rtl/mcdt_pkg.sv =====
// ----------------------------------------------------------------------------
// Multi-channel delay timer package
// Shared word types, operation codes and the default channel count for the timer table.
// ----------------------------------------------------------------------------
package mcdt_pkg;

   localparam int CHANNELS_DEFAULT = 16;

   localparam logic [1:0] MODE_TICK     = 2'd0;
   localparam logic [1:0] MODE_ARM      = 2'd1;
   localparam logic [1:0] MODE_CANCEL   = 2'd2;
   localparam logic [1:0] MODE_DISPATCH = 2'd3;

   localparam logic [1:0] KIND_ONESHOT  = 2'd0;
   localparam logic [1:0] KIND_COUNTED  = 2'd1;

   typedef struct packed {
      logic [1:0]  mode;
      logic [3:0]  channel;
      logic [31:0] period;
      logic [1:0]  timer_kind;
      logic [31:0] repeat_count;
   } req_word_type;

   typedef struct packed {
      logic       fired;
      logic [3:0] fired_channel;
   } rsp_word_type;

   // One channel entry as it is kept in the table memory.
   typedef struct packed {
      logic [31:0] remaining;
      logic [31:0] reload_value;
      logic [1:0]  kind;
      logic [31:0] repeats_left;
   } chan_entry_type;

   localparam int ENTRY_W = $bits(chan_entry_type);

endpackage

// ===== hw/rtl/mcdt_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module mcdt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== hw/rtl/multi_channel_delay_timer_unit.sv =====
// ----------------------------------------------------------------------------
// Multi-channel delay timer unit
// A table of one-shot, counted and periodic timer channels kept in one RAM.
// ----------------------------------------------------------------------------
// Tick: the table RAM is walked one entry per cycle.
// Arm: read, write back, result; cancel: write, then result.
// Dispatch: pending flags are scanned one per cycle.
// One word is in work at a time; a finished result waits in the output register.
// Reset clears control state, pending and registered flags, and entry valid bits,
// so every table entry reads as zero without a clearing pass.
module multi_channel_delay_timer_unit #(
   parameter int CHANNELS = mcdt_pkg::CHANNELS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  mcdt_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output mcdt_pkg::rsp_word_type rsp_word
);

   import mcdt_pkg::*;

   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);
   localparam logic [8:0] CH_LIMIT = 9'(CHANNELS);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_TICK = 3'd1;
   localparam logic [2:0] S_ARM  = 3'd2;
   localparam logic [2:0] S_SCAN = 3'd3;
   localparam logic [2:0] S_DISP = 3'd4;
   localparam logic [2:0] S_DONE = 3'd5;

   logic [2:0]          state_ff, state_in;
   logic [CH_W-1:0]     cur_ff, cur_in;
   req_word_type        req_ff, req_in;
   logic                fired_ff, fired_in;
   logic [3:0]          fch_ff, fch_in;
   logic [CHANNELS-1:0] pending_ff, pending_in;
   logic [CHANNELS-1:0] registered_ff, registered_in;
   logic [CHANNELS-1:0] valid_ff, valid_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_word_type        rsp_ff, rsp_in;
   logic                rd_valid_ff;

   logic                ram_wr_en;
   logic [CH_W-1:0]     ram_wr_addr;
   chan_entry_type      ram_wr_data;
   logic [CH_W-1:0]     ram_rd_addr;
   logic [ENTRY_W-1:0]  ram_rd_raw;
   chan_entry_type      rd_entry;
   logic                req_fire;
   logic                ch_in_range;
   logic [CH_W-1:0]     req_ch;

   mcdt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CHANNELS),
      .AW    (CH_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_raw)
   );

   // An entry never written since reset reads as all zeros.
   assign rd_entry    = rd_valid_ff ? chan_entry_type'(ram_rd_raw) : '0;
   assign req_ready   = (state_ff == S_IDLE);
   assign req_fire    = req_valid && req_ready;
   assign ch_in_range = ({5'd0, req_word.channel} < CH_LIMIT);
   assign req_ch      = CH_W'(req_word.channel);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_word    = rsp_ff;

   always_comb begin
      chan_entry_type ent;
      ent           = rd_entry;
      state_in      = state_ff;
      cur_in        = cur_ff;
      req_in        = req_ff;
      fired_in      = fired_ff;
      fch_in        = fch_ff;
      pending_in    = pending_ff;
      registered_in = registered_ff;
      valid_in      = valid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = cur_ff;
      ram_wr_data   = rd_entry;
      ram_rd_addr   = cur_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               req_in   = req_word;
               fired_in = 1'b0;
               fch_in   = '0;
               unique case (req_word.mode)
                  MODE_TICK: begin
                     cur_in      = '0;
                     ram_rd_addr = '0;
                     state_in    = S_TICK;
                  end
                  MODE_ARM: begin
                     if (ch_in_range) begin
                        cur_in      = req_ch;
                        ram_rd_addr = req_ch;
                        state_in    = S_ARM;
                     end else begin
                        state_in = S_DONE;
                     end
                  end
                  MODE_CANCEL: begin
                     if (ch_in_range) begin
                        ram_wr_en             = 1'b1;
                        ram_wr_addr           = req_ch;
                        ram_wr_data           = '0;
                        valid_in[req_ch]      = 1'b1;
                        registered_in[req_ch] = 1'b0;
                     end
                     state_in = S_DONE;
                  end
                  MODE_DISPATCH: begin
                     cur_in   = '0;
                     state_in = S_SCAN;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end

         S_TICK: begin
            // Read of the next entry overlaps the write-back of this one.
            if (rd_entry.remaining != 32'd0) begin
               ent.remaining = rd_entry.remaining - 32'd1;
               if (rd_entry.remaining == 32'd1) begin
                  pending_in[cur_ff] = 1'b1;
                  if (rd_entry.kind != KIND_ONESHOT) begin
                     ent.remaining = rd_entry.reload_value;
                  end
               end
               ram_wr_en        = 1'b1;
               ram_wr_data      = ent;
               valid_in[cur_ff] = 1'b1;
            end
            ram_rd_addr = cur_ff + 1'b1;
            cur_in      = cur_ff + 1'b1;
            if (cur_ff == LAST_CH) begin
               state_in = S_DONE;
            end
         end

         S_ARM: begin
            ent.remaining    = req_ff.period;
            ent.reload_value = (req_ff.timer_kind != KIND_ONESHOT) ?
                               req_ff.period : rd_entry.reload_value;
            ent.kind         = req_ff.timer_kind;
            ent.repeats_left = req_ff.repeat_count;
            ram_wr_en             = 1'b1;
            ram_wr_data           = ent;
            valid_in[cur_ff]      = 1'b1;
            registered_in[cur_ff] = 1'b1;
            state_in              = S_DONE;
         end

         S_SCAN: begin
            if (pending_ff[cur_ff]) begin
               pending_in[cur_ff] = 1'b0;
               if (registered_ff[cur_ff]) begin
                  fired_in = 1'b1;
                  fch_in   = 4'(cur_ff);
                  state_in = S_DISP;
               end else begin
                  state_in = S_DONE;
               end
            end else if (cur_ff == LAST_CH) begin
               state_in = S_DONE;
            end else begin
               cur_in = cur_ff + 1'b1;
            end
         end

         S_DISP: begin
            if (rd_entry.kind == KIND_ONESHOT) begin
               ram_wr_en             = 1'b1;
               ram_wr_data           = '0;
               registered_in[cur_ff] = 1'b0;
            end else if (rd_entry.kind == KIND_COUNTED) begin
               ram_wr_en = 1'b1;
               if (rd_entry.repeats_left == 32'd1) begin
                  ram_wr_data           = '0;
                  registered_in[cur_ff] = 1'b0;
               end else begin
                  ent.repeats_left = rd_entry.repeats_left - 32'd1;
                  ram_wr_data      = ent;
               end
            end
            state_in = S_DONE;
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in        = 1'b1;
               rsp_in.fired         = fired_ff;
               rsp_in.fired_channel = fch_ff;
               state_in            = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         pending_ff    <= '0;
         registered_ff <= '0;
         valid_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         pending_ff    <= pending_in;
         registered_ff <= registered_in;
         valid_ff      <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      req_ff      <= req_in;
      fired_ff    <= fired_in;
      fch_ff      <= fch_in;
      rsp_ff      <= rsp_in;
      rd_valid_ff <= valid_ff[ram_rd_addr];
   end

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff != S_IDLE)
      else $error("accepted word did not start work");

   a_nofire_zero_channel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.fired |-> rsp_ff.fired_channel == 4'd0)
      else $error("non-firing result carries a channel");

   a_disp_flags: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DISP |-> registered_ff[cur_ff] && !pending_ff[cur_ff] && fired_ff)
      else $error("dispatch write-back on an inconsistent channel");

   a_arm_follows_accept: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ARM |-> $past(req_fire))
      else $error("arm write-back without a fresh read");

   a_done_holds_output: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE && rsp_valid_ff && !rsp_ready |=> state_ff == S_DONE)
      else $error("result overwrote a waiting word");

endmodule
